// ===== design/mfr_pkg.sv =====
package mfr_pkg;

  // configuration defaults
  localparam logic [7:0] StartMarkerReset  = 8'hF1;
  localparam logic [7:0] EndMarkerReset    = 8'hF2;
  localparam logic [7:0] EscapeMarkerReset = 8'hF3;

  // default frame depth in bytes
  localparam int BufDepthDefault = 128;

  // configuration port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  // register indexes, byte address is 4 * index
  localparam logic [1:0] RegStart  = 2'd0;
  localparam logic [1:0] RegEnd    = 2'd1;
  localparam logic [1:0] RegEscape = 2'd2;

  // one result word
  typedef struct packed {
    logic       byte_stored;
    logic [6:0] store_index;
    logic [7:0] stored_value;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       overflow;
  } mfr_result_t;

endpackage

// ===== design/mfr_if.sv =====
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_stored;
  logic [6:0] store_index;
  logic [7:0] stored_value;
  logic       frame_done;
  logic [7:0] frame_length;
  logic       overflow;

  modport source (
    output valid, output byte_stored, output store_index, output stored_value,
    output frame_done, output frame_length, output overflow, input ready
  );
  modport sink (
    input valid, input byte_stored, input store_index, input stored_value,
    input frame_done, input frame_length, input overflow, output ready
  );
endinterface

// ===== design/marker_frame_receiver.sv =====
// marker framed byte receiver: takes one received byte per word on in_i and gives
// exactly one result word on out_o for each, telling whether the byte went into
// the frame and at which position, whether an unescaped end marker closed the
// frame (with its length, markers included) and whether the byte was dropped
// because the frame already held BUF_DEPTH bytes. a frame opens when the byte at
// position 0 equals the start marker; escape bytes are kept as data and make
// the following marker literal inside a frame. no frame memory is held: every
// stored byte leaves with its index. a byte is accepted whenever the skid word
// is empty; its result is registered in the output register, and a one-word
// skid stage lets a further byte in while that result waits, so throughput is
// one byte per clock as long as out_o is drained. the markers are set over the
// apb port at addresses 0x0 (start), 0x4 (end) and 0x8 (escape); the user must
// write them only while no byte is in flight, the block does not enforce this.
module marker_frame_receiver #(
  parameter int BUF_DEPTH = mfr_pkg::BufDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  mfr_in_if.sink                    in_i,
  mfr_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mfr_pkg::AddrW-1:0] paddr,
  input  logic [mfr_pkg::DataW-1:0] pwdata,
  output logic [mfr_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import mfr_pkg::*;

  // write index holds 0 .. BUF_DEPTH
  localparam int WiW  = $clog2(BUF_DEPTH + 1);
  localparam int ExtW = (WiW > 8) ? WiW : 8;

  // marker registers
  logic [7:0] start_q;
  logic [7:0] end_q;
  logic [7:0] escape_q;

  // framing state
  logic           esc_pending_q, esc_pending_d;
  logic [WiW-1:0] wi_q, wi_d;
  logic [7:0]     first_q, first_d;

  logic        accept;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [7:0]  b;
  logic        is_start, is_end, is_esc, open;
  logic        store_req, restart, close;
  logic        full, stored;
  logic [WiW-1:0] wi_base, wi_after;
  logic [ExtW-1:0] base_ext, after_ext;
  mfr_result_t res;
  logic        skid_ready;

  // ---------------------------------------------------------------------------
  // apb configuration, single wait-free access
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= StartMarkerReset;
      end_q    <= EndMarkerReset;
      escape_q <= EscapeMarkerReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegStart:  start_q  <= pwdata[7:0];
        RegEnd:    end_q    <= pwdata[7:0];
        RegEscape: escape_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegStart:  prdata = {{(DataW-8){1'b0}}, start_q};
      RegEnd:    prdata = {{(DataW-8){1'b0}}, end_q};
      RegEscape: prdata = {{(DataW-8){1'b0}}, escape_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // framing decision for the byte on the input
  // ---------------------------------------------------------------------------
  assign in_i.ready = skid_ready;
  assign accept     = in_i.valid && skid_ready;
  assign b          = in_i.in_byte;

  assign is_start = (b == start_q);
  assign is_end   = (b == end_q);
  assign is_esc   = (b == escape_q);
  // frame open while position 0 holds the start marker
  assign open     = (first_q == start_q);

  always_comb begin
    store_req = 1'b0;
    restart   = 1'b0;
    close     = 1'b0;
    if (is_start) begin
      // start wins over end when both markers match; an escaped start
      // inside a frame is plain data
      store_req = 1'b1;
      restart   = !(esc_pending_q && open);
    end else if (is_end) begin
      if (open) begin
        store_req = 1'b1;
        close     = !esc_pending_q;
      end
    end else if (open) begin
      store_req = 1'b1;
    end
  end

  assign wi_base  = restart ? '0 : wi_q;
  assign full     = (wi_base >= WiW'(BUF_DEPTH));
  assign stored   = store_req && !full;
  assign wi_after = stored ? wi_base + WiW'(1) : wi_base;

  assign base_ext  = ExtW'(wi_base);
  assign after_ext = ExtW'(wi_after);

  // next state
  assign first_d       = (stored && (wi_base == '0)) ? b : first_q;
  assign wi_d          = close ? '0 : wi_after;
  assign esc_pending_d = is_esc && !esc_pending_q;

  always_comb begin
    res.byte_stored  = stored;
    res.store_index  = stored ? base_ext[6:0] : 7'd0;
    res.stored_value = stored ? b : 8'd0;
    res.frame_done   = close;
    // a full frame still closes, length stays at the depth
    res.frame_length = close ? after_ext[7:0] : 8'd0;
    res.overflow     = store_req && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pending_q <= 1'b0;
      wi_q          <= '0;
      first_q       <= 8'd0;
    end else if (accept) begin
      esc_pending_q <= esc_pending_d;
      wi_q          <= wi_d;
      first_q       <= first_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register with skid word
  // ---------------------------------------------------------------------------
  mfr_result_t out_data;

  mfr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (skid_ready),
    .in_data_i   (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.byte_stored  = out_data.byte_stored;
  assign out_o.store_index  = out_data.store_index;
  assign out_o.stored_value = out_data.stored_value;
  assign out_o.frame_done   = out_data.frame_done;
  assign out_o.frame_length = out_data.frame_length;
  assign out_o.overflow     = out_data.overflow;

endmodule

// ===== design/mfr_skid.sv =====
module mfr_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mfr_pkg::mfr_result_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mfr_pkg::mfr_result_t out_data_o
);
  import mfr_pkg::*;

  logic        out_valid_q;
  logic        skid_valid_q;
  mfr_result_t out_data_q;
  mfr_result_t skid_data_q;
  logic        out_free;

  assign out_free   = out_ready_i || !out_valid_q;
  assign in_ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_data_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== bench/marker_frame_receiver_tb.sv =====
module marker_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfr_pkg::*;

  localparam int Depth      = BufDepthDefault;
  localparam int MaxIdle    = 12;
  // worst case is roughly 650 words with idling on both sides, plus holds
  localparam int CycleLimit = 200000;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  // apb configuration port
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  mfr_in_if  in_if ();
  mfr_out_if out_if ();

  marker_frame_receiver #(
    .BUF_DEPTH(Depth)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 8 ns period, two half-period delays
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // framing predictor: own copy of the marker registers and the frame state
  // ---------------------------------------------------------------------------
  logic [7:0] start_mk  = StartMarkerReset;
  logic [7:0] end_mk    = EndMarkerReset;
  logic [7:0] escape_mk = EscapeMarkerReset;

  bit         esc_seen  = 1'b0;   // previous byte was an unescaped escape
  int         next_pos  = 0;      // next frame position, saturates at Depth
  logic [7:0] head_byte = 8'h00;  // byte held at position 0, start marker = frame open

  mfr_result_t pending_results[$];

  int mismatches   = 0;
  int words_sent   = 0;
  int src_max_gap  = MaxIdle;
  int snk_max_wait = MaxIdle;
  int snk_hold     = 0;           // long receiver hold-off, counted down by the receiver
  int src_gap      = 0;           // idle cycles before the next input word
  bit src_held     = 1'b0;        // valid left high for a back-to-back word

  // write one byte into the predicted frame, or flag it as dropped when full
  function automatic void place_byte(input logic [7:0] b, inout mfr_result_t r);
    if (next_pos >= Depth) begin
      r.overflow = 1'b1;
    end else begin
      if (next_pos == 0) head_byte = b;
      r.byte_stored  = 1'b1;
      r.store_index  = next_pos[6:0];
      r.stored_value = b;
      next_pos++;
    end
  endfunction

  // result word caused by one received byte; advances the predicted state
  function automatic mfr_result_t frame_outcome(input logic [7:0] b);
    mfr_result_t r;
    bit          in_frame;
    r        = '0;
    in_frame = (head_byte == start_mk);
    // start test first, so equal markers act as a start
    if (b == start_mk) begin
      // an escaped start inside an open frame is plain data
      if (!(esc_seen && in_frame)) next_pos = 0;
      place_byte(b, r);
    end else if (b == end_mk) begin
      // an end with no frame open is ignored altogether
      if (in_frame) begin
        place_byte(b, r);
        if (!esc_seen) begin
          r.frame_done   = 1'b1;
          r.frame_length = next_pos[7:0];
          next_pos       = 0;
        end
      end
    end else if (in_frame) begin
      place_byte(b, r);
    end
    // an escaped escape does not arm the next byte
    esc_seen = (b == escape_mk) && !esc_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    repeat (src_gap) @(posedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(frame_outcome(b));
    words_sent++;
    // gap before the next word; with no gap valid simply stays high
    src_gap = $urandom_range(0, src_max_gap);
    if (src_gap > 0) begin
      in_if.valid <= 1'b0;
      src_held = 1'b0;
    end else begin
      src_held = 1'b1;
    end
  endtask

  // lower valid if it was left up for a back-to-back word that never came
  task automatic release_input();
    if (src_held) begin
      in_if.valid <= 1'b0;
      src_held = 1'b0;
    end
  endtask

  // wait until every expected word is back and the block has gone quiet
  task automatic drain();
    release_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    src_gap = 0;
  endtask

  function automatic logic [7:0] random_data();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == start_mk || b == end_mk || b == escape_mk);
    return b;
  endfunction

  function automatic logic [7:0] any_marker();
    case ($urandom_range(0, 2))
      0:       return start_mk;
      1:       return end_mk;
      default: return escape_mk;
    endcase
  endfunction

  // mostly well formed: start, body with escaped markers and the odd stray, end
  task automatic send_frame(input int body_len);
    send_byte(start_mk);
    for (int i = 0; i < body_len; i++) begin
      case ($urandom_range(0, 9))
        0:       begin send_byte(escape_mk); send_byte(any_marker()); end
        1:       send_byte(8'($urandom_range(0, 255)));
        default: send_byte(random_data());
      endcase
    end
    // now and then the end marker is missing
    if ($urandom_range(0, 7) != 0) send_byte(end_mk);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) send_byte(any_marker());
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_traffic(input int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 15) == 0) send_frame($urandom_range(13, 40));
        else send_frame($urandom_range(0, 12));
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // configuration side
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input logic wr, input logic [1:0] reg_id,
                          input logic [7:0] wval, output logic [7:0] rval);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'({reg_id, 2'b00});
    pwdata  <= DataW'(wval);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rval = prdata[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_marker(input logic [1:0] reg_id, input logic [7:0] value);
    logic [7:0] rd;
    apb_xfer(1'b1, reg_id, value, rd);
    case (reg_id)
      RegStart:  start_mk  = value;
      RegEnd:    end_mk    = value;
      RegEscape: escape_mk = value;
      default:   ;
    endcase
    apb_xfer(1'b0, reg_id, 8'h00, rd);
    if (rd !== value) begin
      $display("%0t: register %0d readback expected %02h got %02h", $realtime, reg_id,
               value, rd);
      mismatches++;
    end
  endtask

  task automatic apply_markers(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x);
    drain();
    set_marker(RegStart, s);
    set_marker(RegEnd, e);
    set_marker(RegEscape, x);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, long hold-off on request, word checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0h got %0h", $realtime, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic check_word();
    mfr_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result word with nothing expected, stored %0b index %0d value %02h",
               $realtime, out_if.byte_stored, out_if.store_index, out_if.stored_value);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      check_field("byte_stored",  8'(want.byte_stored),  8'(out_if.byte_stored));
      check_field("store_index",  8'(want.store_index),  8'(out_if.store_index));
      check_field("stored_value", want.stored_value,     out_if.stored_value);
      check_field("frame_done",   8'(want.frame_done),   8'(out_if.frame_done));
      check_field("frame_length", want.frame_length,     out_if.frame_length);
      check_field("overflow",     8'(want.overflow),     8'(out_if.overflow));
    end
  endtask

  initial begin
    int   stall;
    logic rdy;
    stall = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        check_word();
        stall = $urandom_range(0, snk_max_wait);
      end
      // the long hold-off wins over the per-word stall
      if (snk_hold > 0) begin
        rdy = 1'b0;
        snk_hold--;
      end else if (stall > 0) begin
        rdy = 1'b0;
        stall--;
      end else begin
        rdy = 1'b1;
      end
      out_if.ready <= rdy;
    end
  end

  // cycle limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL marker_frame_receiver");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset markers: ignored bytes outside a frame, escapes, the frame left open after an end
  task automatic test_reset_markers();
    send_byte(8'h00);   // data with no frame open
    send_byte(8'hF2);   // end with no frame open
    send_byte(8'hF3);   // escape with no frame open, still arms the next byte
    send_byte(8'hF1);   // escaped start outside a frame opens it anyway
    send_byte(8'hFF);
    send_byte(8'hF3);
    send_byte(8'hF2);   // escaped end is data
    send_byte(8'hF3);
    send_byte(8'hF3);   // escaped escape is data and does not arm
    send_byte(8'hF2);   // real end, length 7
    send_byte(8'h55);   // lands at position 0 and closes the frame
    send_byte(8'h12);   // ignored
    send_byte(8'hF1);
    send_byte(8'hF3);
    send_byte(8'hF1);   // escaped start inside a frame is data
    send_byte(8'hF1);   // real start restarts at position 0
    send_byte(8'hF2);
    send_byte(8'hF1);   // after an end the frame stays open
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hF2);
  endtask

  // fill the frame past its depth, dropped bytes, escaped and real end when full
  task automatic test_frame_full();
    send_byte(start_mk);
    for (int i = 0; i < Depth + 1; i++) send_byte(random_data());
    send_byte(escape_mk);
    send_byte(end_mk);  // escaped end while full: dropped, no close
    send_byte(end_mk);  // real end while full: closes with full length
    send_byte(start_mk);
    for (int i = 0; i < Depth; i++) send_byte(random_data());
    send_byte(start_mk);  // start while full restarts the frame
    send_byte(end_mk);
  endtask

  // extreme and colliding marker values
  task automatic test_marker_extremes();
    logic [7:0] sets [6][3];
    sets = '{'{8'h00, 8'hFF, 8'h80}, '{8'hFF, 8'h00, 8'h01}, '{8'h5A, 8'h5A, 8'hA5},
             '{8'h10, 8'h20, 8'h20}, '{8'h33, 8'h33, 8'h33}, '{8'hC3, 8'h3C, 8'hC3}};
    for (int i = 0; i < 6; i++) begin
      apply_markers(sets[i][0], sets[i][1], sets[i][2]);
      random_traffic(20);
    end
  endtask

  // random markers under different idling mixes, back to reset values at the end
  task automatic test_random_markers();
    int src_caps [4];
    int snk_caps [4];
    src_caps = '{MaxIdle, 0, 0, MaxIdle};
    snk_caps = '{MaxIdle, 0, MaxIdle, 0};
    for (int i = 0; i < 4; i++) begin
      apply_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      src_max_gap  = src_caps[i];
      snk_max_wait = snk_caps[i];
      random_traffic(25);
    end
    src_max_gap  = MaxIdle;
    snk_max_wait = MaxIdle;
    apply_markers(StartMarkerReset, EndMarkerReset, EscapeMarkerReset);
    random_traffic(30);
  endtask

  // receiver holds off while words keep coming, so the input side has to stall
  task automatic test_output_hold();
    drain();
    src_max_gap = 0;
    snk_hold    = 80;
    send_frame(30);
    src_max_gap = MaxIdle;
    random_traffic(20);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'h00;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_markers();
    test_frame_full();
    test_marker_extremes();
    test_random_markers();
    test_output_hold();

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS marker_frame_receiver");
    end else begin
      $display("FAIL marker_frame_receiver");
    end
    $finish;
  end

endmodule

// ===== marker_frame_receiver.f =====
design/mfr_pkg.sv
design/mfr_if.sv
design/mfr_skid.sv
design/marker_frame_receiver.sv
bench/marker_frame_receiver_tb.sv
